// File: hdl/bsrw_pkg.sv
// Shared types, constants and pixel conversion functions for the BMP stream writer.
// No dependencies; used by the front, queue, back and top-level modules.
package bsrw_pkg;

  // Widest coordinate the command struct carries
  localparam int unsigned COORD_MAX    = 16;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned SCREEN_W_RST = 800;
  localparam int unsigned SCREEN_H_RST = 480;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [31:0] HEADER_LEN    = 32'd54;
  localparam logic [5:0]  HEADER_LAST   = 6'd53;

  // Result kinds
  localparam logic [1:0] KIND_CURSOR = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_UNSUPPORTED = 2'd0;
  localparam logic [1:0] ERR_SIZE        = 2'd1;
  localparam logic [1:0] ERR_TOO_LARGE   = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED   = 2'd3;

  // Configuration register indexes
  localparam logic CFG_SCREEN_W = 1'b0;
  localparam logic CFG_SCREEN_H = 1'b1;

  typedef struct packed {
    logic cursor;
    logic pixel;
    logic done;
    logic error;
  } cmd_flags_t;

  typedef struct packed {
    cmd_flags_t            flags;
    logic [1:0]            error_code;
    logic [COORD_MAX-1:0]  pos_x;
    logic [COORD_MAX-1:0]  pos_y;
    logic [15:0]           pixel;
  } cmd_t;

  // BGR233 byte to BGR565
  function automatic logic [15:0] expand_233(input logic [7:0] p);
    expand_233 = {p[7:6], 3'b000, p[5:3], 3'b000, p[2:0], 2'b00};
  endfunction

  // B, G, R bytes to BGR565
  function automatic logic [15:0] pack_888(input logic [7:0] b, input logic [7:0] g,
                                           input logic [7:0] r);
    pack_888 = {b[7:3], g[7:2], r[7:3]};
  endfunction

endpackage

// File: hdl/bsrw_front.sv
// Front part: parses the BMP header, checks it and walks the pixel rows.
// Uses bsrw_pkg; pushes at most one command per byte or header check to the queue.
module bsrw_front import bsrw_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  input  logic [COORD_BITS-1:0] screen_w,
  input  logic [COORD_BITS-1:0] screen_h,
  input  logic                  q_full,
  output logic                  push,
  output cmd_t                  cmd
);

  localparam int unsigned RB = COORD_BITS + 2;

  typedef enum logic [7:0] {
    PH_HEADER = 8'b0000_0001,
    PH_CHK1   = 8'b0000_0010,
    PH_CHK2   = 8'b0000_0100,
    PH_CHK3   = 8'b0000_1000,
    PH_CHK4   = 8'b0001_0000,
    PH_SKIP   = 8'b0010_0000,
    PH_ROWS   = 8'b0100_0000,
    PH_DRAIN  = 8'b1000_0000
  } phase_t;

  phase_t                phase;
  logic [31:0]           byte_count;
  logic [31:0]           pixel_offset;
  logic [31:0]           img_width;
  logic [31:0]           img_height;
  logic [31:0]           compress_mode;
  logic [31:0]           declared_size;
  logic [31:0]           prod;
  logic [15:0]           sig_word;
  logic [15:0]           depth_bits;
  logic [15:0]           partial;
  logic                  bad;
  logic                  last_pend;
  logic [RB-1:0]         line_len;
  logic [RB-1:0]         pix_bytes;
  logic [RB-1:0]         bir;
  logic [1:0]            sub;
  logic [COORD_BITS-1:0] row_index;
  logic [COORD_BITS-1:0] origin_x;
  logic [COORD_BITS-1:0] origin_y;

  logic                  accept;
  logic                  rearm;
  logic [5:0]            hb;
  logic [5:0]            hoff;
  logic [1:0]            bpp;
  logic                  in_pix;
  logic                  emit_pix;
  logic [RB-1:0]         bir_inc;
  logic                  row_end;
  logic                  row_done;
  logic                  trunc;
  logic                  chk_go;
  logic                  mis;
  logic                  big;
  logic                  empty;
  logic                  chk_fail;
  logic [15:0]           pix_val;
  logic [COORD_BITS-1:0] cur_y;

  assign in_ready = (phase == PH_HEADER || phase == PH_SKIP || phase == PH_ROWS ||
                     phase == PH_DRAIN) && !q_full;
  assign accept   = in_valid && in_ready;
  assign rearm    = accept && in_last && !(phase == PH_HEADER && hb == HEADER_LAST);
  assign hb       = byte_count[5:0];
  assign bpp      = depth_bits[4:3];

  // Row walk decode
  always_comb begin
    hoff     = 6'(hb - 6'd10);
    in_pix   = bir < pix_bytes;
    emit_pix = in_pix && ((bpp == 2'd1) || (bpp == 2'd2 && sub == 2'd1) ||
                          (bpp == 2'd3 && sub == 2'd2));
    bir_inc  = RB'(bir + 1'b1);
    row_end  = bir_inc >= line_len;
    row_done = row_end && (row_index == '0);
    cur_y    = COORD_BITS'(origin_y + row_index);
    case (bpp)
      2'd1:    pix_val = expand_233(in_byte);
      2'd2:    pix_val = {in_byte, partial[7:0]};
      default: pix_val = pack_888(partial[7:0], partial[15:8], in_byte);
    endcase
  end

  // Header check outcome and truncation detect
  always_comb begin
    chk_go   = (phase == PH_CHK4) && !q_full;
    mis      = declared_size != prod;
    big      = (img_width > 32'(screen_w)) || (img_height > 32'(screen_h));
    empty    = (img_width == '0) || (img_height == '0);
    chk_fail = bad || mis || big;
    trunc    = accept && in_last && (phase != PH_DRAIN) &&
               !(phase == PH_ROWS && row_done) &&
               !(phase == PH_HEADER && hb == HEADER_LAST);
  end

  // Build the command for this cycle
  always_comb begin
    cmd              = '0;
    cmd.flags.cursor = accept && (phase == PH_ROWS) && (bir == '0);
    cmd.flags.pixel  = accept && (phase == PH_ROWS) && emit_pix;
    cmd.flags.done   = (accept && (phase == PH_ROWS) && row_done) ||
                       (chk_go && !chk_fail && empty);
    cmd.flags.error  = trunc || (chk_go && chk_fail) ||
                       (chk_go && !chk_fail && !empty && last_pend);
    cmd.pos_x        = COORD_MAX'(origin_x);
    cmd.pos_y        = COORD_MAX'(cur_y);
    cmd.pixel        = pix_val;
    if (chk_go && bad)       cmd.error_code = ERR_UNSUPPORTED;
    else if (chk_go && mis)  cmd.error_code = ERR_SIZE;
    else if (chk_go && big)  cmd.error_code = ERR_TOO_LARGE;
    else                     cmd.error_code = ERR_TRUNCATED;
    push = cmd.flags.cursor || cmd.flags.pixel || cmd.flags.done || cmd.flags.error;
  end

  // Header capture
  always_ff @(posedge clk) begin
    if (phase == PH_HEADER && accept) begin
      if (hb < 6'd2)                    sig_word[8*hb[0] +: 8]          <= in_byte;
      else if (hb >= 6'd10 && hb < 6'd14) pixel_offset[8*hoff[1:0] +: 8]  <= in_byte;
      else if (hb >= 6'd18 && hb < 6'd22)
        img_width[8*2'(hb[1:0] - 2'd2) +: 8] <= in_byte;
      else if (hb >= 6'd22 && hb < 6'd26)
        img_height[8*2'(hb[1:0] - 2'd2) +: 8] <= in_byte;
      else if (hb >= 6'd28 && hb < 6'd30) depth_bits[8*hb[0] +: 8]        <= in_byte;
      else if (hb >= 6'd30 && hb < 6'd34) compress_mode[8*hoff[1:0] +: 8] <= in_byte;
      else if (hb >= 6'd34 && hb < 6'd38)
        declared_size[8*2'(hb[1:0] - 2'd2) +: 8] <= in_byte;
    end
  end

  // Sequence header checks and row walk
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      byte_count <= '0;
      bir        <= '0;
      sub        <= '0;
      last_pend  <= 1'b0;
    end else if (rearm) begin
      // Re-arm after the final byte of a file
      phase      <= PH_HEADER;
      byte_count <= '0;
      bir        <= '0;
      sub        <= '0;
      last_pend  <= 1'b0;
    end else begin
      unique case (phase)
        PH_HEADER: begin
          if (accept) begin
            byte_count <= byte_count + 32'd1;
            if (hb == HEADER_LAST) begin
              phase     <= PH_CHK1;
              last_pend <= in_last;
            end
          end
        end
        PH_CHK1: begin
          bad   <= (sig_word != BMP_SIGNATURE) || (compress_mode != '0) ||
                   (depth_bits != 16'd8 && depth_bits != 16'd16 && depth_bits != 16'd24) ||
                   (pixel_offset < HEADER_LEN);
          prod  <= 32'(img_width * 32'(depth_bits));
          phase <= PH_CHK2;
        end
        PH_CHK2: begin
          // Round the line up to a multiple of four bytes
          prod  <= ((prod >> 3) + 32'd3) & ~32'd3;
          phase <= PH_CHK3;
        end
        PH_CHK3: begin
          line_len <= RB'(prod);
          prod     <= 32'(img_height * prod);
          phase    <= PH_CHK4;
        end
        PH_CHK4: begin
          if (!q_full) begin
            origin_x  <= COORD_BITS'((screen_w - img_width[COORD_BITS-1:0]) >> 1);
            origin_y  <= COORD_BITS'((screen_h - img_height[COORD_BITS-1:0]) >> 1);
            row_index <= COORD_BITS'(img_height - 32'd1);
            pix_bytes <= RB'(RB'(img_width[COORD_BITS-1:0]) * RB'(bpp));
            bir       <= '0;
            sub       <= '0;
            if (last_pend) begin
              phase      <= PH_HEADER;
              byte_count <= '0;
              last_pend  <= 1'b0;
            end else if (chk_fail || empty) begin
              phase <= PH_DRAIN;
            end else if (pixel_offset == HEADER_LEN) begin
              phase <= PH_ROWS;
            end else begin
              phase <= PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (accept) begin
            byte_count <= byte_count + 32'd1;
            if (byte_count + 32'd1 == pixel_offset) phase <= PH_ROWS;
          end
        end
        PH_ROWS: begin
          if (accept) begin
            if (in_pix && sub == 2'd0)                partial[7:0]  <= in_byte;
            if (in_pix && sub == 2'd1 && bpp == 2'd3) partial[15:8] <= in_byte;
            if (row_end) begin
              bir <= '0;
              sub <= '0;
              if (row_index == '0) phase <= PH_DRAIN;
              else                 row_index <= row_index - 1'b1;
            end else begin
              bir <= bir_inc;
              if (in_pix) sub <= (sub == bpp - 2'd1) ? 2'd0 : sub + 2'd1;
            end
          end
        end
        PH_DRAIN: ;
        default: phase <= PH_HEADER;
      endcase
    end
  end

  a_no_input_in_check: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CHK1 || phase == PH_CHK2 || phase == PH_CHK3 || phase == PH_CHK4)
      |-> !in_ready)
    else $error("input taken during header check");

  a_done_xor_error: assert property (@(posedge clk) disable iff (rst)
    push |-> !(cmd.flags.done && cmd.flags.error))
    else $error("command carries both done and error");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ROWS) |-> (line_len != '0))
    else $error("row walk with zero line length");

endmodule

// File: hdl/bsrw_queue.sv
// Short command queue between front and back parts.
// Uses bsrw_pkg for the command type and depth.
module bsrw_queue import bsrw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic avail,
  output cmd_t head
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = count == CW'(QUEUE_DEPTH);
  assign avail = count != '0;
  assign head  = entries[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= CW'(count + CW'(push) - CW'(pop));
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("command queue overflow");

endmodule

// File: hdl/bsrw_back.sv
// Back part: expands each queued command into result items on the output stream.
// Uses bsrw_pkg for the command type and result kinds.
module bsrw_back import bsrw_pkg::*; #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned OUT_W      = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_avail,
  input  cmd_t             q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_kind,
  output logic [OUT_W-1:0] out_data
);

  cmd_t       cur;
  cmd_flags_t flags_next;
  logic       load;
  logic       have;

  assign load  = !out_valid || out_ready;
  assign have  = cur.flags.cursor || cur.flags.pixel || cur.flags.done || cur.flags.error;
  assign q_pop = q_avail && !have;

  // Clear the flag that goes out this cycle
  always_comb begin
    flags_next = cur.flags;
    if (load) begin
      if (cur.flags.cursor)     flags_next.cursor = 1'b0;
      else if (cur.flags.pixel) flags_next.pixel  = 1'b0;
      else if (cur.flags.done)  flags_next.done   = 1'b0;
      else                      flags_next.error  = 1'b0;
    end
  end

  // Hold the current command
  always_ff @(posedge clk) begin
    if (rst) begin
      cur.flags <= '0;
    end else if (q_pop) begin
      cur <= q_head;
    end else begin
      cur.flags <= flags_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= have;
      out_data  <= '0;
      if (cur.flags.cursor) begin
        out_kind <= KIND_CURSOR;
        out_data[COORD_BITS-1:0]            <= cur.pos_x[COORD_BITS-1:0];
        out_data[2*COORD_BITS-1:COORD_BITS] <= cur.pos_y[COORD_BITS-1:0];
      end else if (cur.flags.pixel) begin
        out_kind <= KIND_PIXEL;
        out_data[2*COORD_BITS +: 16] <= cur.pixel;
      end else if (cur.flags.done) begin
        out_kind <= KIND_DONE;
      end else begin
        out_kind <= KIND_ERROR;
        out_data[2*COORD_BITS+16 +: 2] <= cur.error_code;
      end
    end
  end

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !have)
    else $error("command popped over a pending one");

endmodule

// File: hdl/bmp_stream_to_rgb565_writer.sv
// Top level of the BMP stream to BGR565 writer: configuration registers and wiring.
// Depends on bsrw_pkg, bsrw_front, bsrw_queue and bsrw_back.
//
// Feed a BMP file one byte per item on s_axis, tlast on the final byte. The
// 54-byte header is checked (signature, no compression, 8/16/24-bit depth,
// size against rows times padded line length, dimensions against the screen);
// then one cursor item opens each row, bottom row first and centred, followed
// by one BGR565 pixel item per source pixel and a done item after the top row.
// Failures give one error item; a file cut short gives a truncated error.
// Header, skip and padding bytes are accepted whenever the queue is not full;
// after the last header byte the header check steps through flag checks with
// width times depth, rounding to whole words, height times line length, then
// the verdict, which waits while the queue is full. Every byte that yields
// results becomes one queued command; the back part takes a new command only
// once it holds none, then sends that command's result items one at a time,
// cursor first. Once the two-entry queue fills, input waits on the back part
// and on output stalls.
module bmp_stream_to_rgb565_writer import bsrw_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // data_byte
  input  logic                              s_axis_tlast,  // last_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [((2*COORD_BITS+18+7)/8)*8-1:0] m_axis_tdata, // pos_x, pos_y, pixel, error_code
  output logic [1:0]                        m_axis_tuser,  // kind
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [COORD_BITS-1:0]             cfg_data
);

  localparam int unsigned OUT_W = ((2*COORD_BITS + 18 + 7) / 8) * 8;

  logic [COORD_BITS-1:0] screen_w;
  logic [COORD_BITS-1:0] screen_h;
  logic                  q_full;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_avail;
  cmd_t                  push_cmd;
  cmd_t                  head_cmd;

  // Screen size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_w <= COORD_BITS'(SCREEN_W_RST);
      screen_h <= COORD_BITS'(SCREEN_H_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_W: screen_w <= cfg_data;
        CFG_SCREEN_H: screen_h <= cfg_data;
        default: ;
      endcase
    end
  end

  bsrw_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .screen_w (screen_w),
    .screen_h (screen_h),
    .q_full   (q_full),
    .push     (q_push),
    .cmd      (push_cmd)
  );

  bsrw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head     (head_cmd)
  );

  bsrw_back #(.COORD_BITS(COORD_BITS), .OUT_W(OUT_W)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_avail   (q_avail),
    .q_head    (head_cmd),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (m_axis_tuser),
    .out_data  (m_axis_tdata)
  );

endmodule

// File: test/testbench.sv
// Self-checking testbench for bmp_stream_to_rgb565_writer: sends BMP files one byte per item
// and checks each result item against a built-in behavioral predictor. Depends on bsrw_pkg.
`timescale 1ns / 1ps

module testbench;
  import bsrw_pkg::*;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned TDATA_W = ((2*COORD_BITS+18+7)/8)*8;
  localparam logic [31:0] COORD_MASK = 32'h0000_0FFF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 20;

  typedef enum logic [1:0] {PH_HEADER, PH_SKIP, PH_ROWS, PH_DRAIN} parse_phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [15:0] pixel;
    logic [1:0]  error_code;
  } bmp_result_t;

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [7:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_we, cfg_index;
  logic [COORD_BITS-1:0] cfg_data;

  bmp_stream_to_rgb565_writer #(.COORD_BITS(COORD_BITS)) u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state
  logic [31:0] scr_w, scr_h;
  parse_phase_t ph;
  logic [31:0] byte_cnt, pix_off, img_w, img_h, comp_mode, decl_size, line_len;
  logic [31:0] row_idx, row_byte, partial, org_x, org_y;
  logic [15:0] sig, depth;

  bmp_result_t expected_results[$];
  logic [7:0] file_bytes[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit send_gaps = 1, recv_stalls = 1;

  // Clock and cycle limit
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic void push_result(logic [1:0] kind, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] pix, logic [1:0] err);
    bmp_result_t r;
    r.kind = kind;
    r.pos_x = x[11:0];
    r.pos_y = y[11:0];
    r.pixel = pix[15:0];
    r.error_code = err;
    expected_results.push_back(r);
  endfunction

  function automatic void clear_parse();
    ph = PH_HEADER;
    byte_cnt = 0; sig = 0; pix_off = 0; img_w = 0; img_h = 0; depth = 0;
    comp_mode = 0; decl_size = 0; line_len = 0; row_idx = 0; row_byte = 0;
    partial = 0; org_x = 0; org_y = 0;
  endfunction

  // Check the collected header and set up the row walk
  function automatic void check_header();
    logic [31:0] ln;
    ph = PH_DRAIN;
    if (sig != BMP_SIGNATURE || comp_mode != 0 ||
        (depth != 8 && depth != 16 && depth != 24) || pix_off < 54) begin
      push_result(KIND_ERROR, 0, 0, 0, ERR_UNSUPPORTED);
      return;
    end
    ln = (img_w * {16'd0, depth}) >> 3;
    if (ln[1:0] != 2'd0) ln = ln + 32'd4 - {30'd0, ln[1:0]};
    line_len = ln;
    if (decl_size != img_h * ln) begin
      push_result(KIND_ERROR, 0, 0, 0, ERR_SIZE);
      return;
    end
    if (img_w > scr_w || img_h > scr_h) begin
      push_result(KIND_ERROR, 0, 0, 0, ERR_TOO_LARGE);
      return;
    end
    org_x = ((scr_w - img_w) >> 1) & COORD_MASK;
    org_y = ((scr_h - img_h) >> 1) & COORD_MASK;
    if (img_w == 0 || img_h == 0) begin
      push_result(KIND_DONE, 0, 0, 0, 0);
      return;
    end
    row_idx = (img_h - 1) & COORD_MASK;
    row_byte = 0;
    ph = (pix_off == 54) ? PH_ROWS : PH_SKIP;
  endfunction

  // Convert one pixel-area byte, emitting cursor, pixel and done as they fall due
  function automatic void convert_row_byte(logic [7:0] b);
    logic [31:0] bpp, pix_bytes, sub, bw;
    bw = {24'd0, b};
    bpp = {16'd0, depth} >> 3;
    pix_bytes = img_w * bpp;
    if (row_byte == 0) push_result(KIND_CURSOR, org_x, org_y + row_idx, 0, 0);
    if (row_byte < pix_bytes) begin
      sub = row_byte % bpp;
      if (bpp == 1) begin
        push_result(KIND_PIXEL, 0, 0,
                    ((bw << 8) & 32'hC000) | ((bw << 5) & 32'h700) | ((bw << 2) & 32'h1C), 0);
      end else if (bpp == 2) begin
        if (sub == 0) partial = bw;
        else push_result(KIND_PIXEL, 0, 0, partial | (bw << 8), 0);
      end else begin
        if (sub == 0) partial = bw;
        else if (sub == 1) partial = partial | (bw << 8);
        else push_result(KIND_PIXEL, 0, 0, (bw >> 3) | (((partial >> 8) << 3) & 32'h7E0) |
                         ((partial << 8) & 32'hF800), 0);
      end
    end
    row_byte = row_byte + 1;
    if (row_byte >= line_len) begin
      row_byte = 0;
      if (row_idx == 0) begin
        ph = PH_DRAIN;
        push_result(KIND_DONE, 0, 0, 0, 0);
      end else begin
        row_idx = row_idx - 1;
      end
    end
  endfunction

  // Advance the predictor by one accepted byte
  function automatic void predict_byte(logic [7:0] b, logic last);
    logic [31:0] p;
    p = byte_cnt;
    case (ph)
      PH_HEADER: begin
        if (p < 2) sig[8*p +: 8] = b;
        else if (p >= 10 && p < 14) pix_off[8*(p-10) +: 8] = b;
        else if (p >= 18 && p < 22) img_w[8*(p-18) +: 8] = b;
        else if (p >= 22 && p < 26) img_h[8*(p-22) +: 8] = b;
        else if (p >= 28 && p < 30) depth[8*(p-28) +: 8] = b;
        else if (p >= 30 && p < 34) comp_mode[8*(p-30) +: 8] = b;
        else if (p >= 34 && p < 38) decl_size[8*(p-34) +: 8] = b;
        byte_cnt = byte_cnt + 1;
        if (byte_cnt == 54) check_header();
      end
      PH_SKIP: begin
        byte_cnt = byte_cnt + 1;
        if (byte_cnt == pix_off) ph = PH_ROWS;
      end
      PH_ROWS: convert_row_byte(b);
      default: ;
    endcase
    if (last) begin
      if (ph != PH_DRAIN) push_result(KIND_ERROR, 0, 0, 0, ERR_TRUNCATED);
      clear_parse();
    end
  endfunction

  // Result side: random stall bursts
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_stalls && $urandom_range(0, 5) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    bmp_result_t want;
    logic [11:0] got_x, got_y;
    logic [15:0] got_pix;
    logic [1:0] got_err;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_x = m_axis_tdata[11:0];
      got_y = m_axis_tdata[23:12];
      got_pix = m_axis_tdata[39:24];
      got_err = m_axis_tdata[41:40];
      if (expected_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result kind=%0d x=%0d y=%0d pixel=%h err=%0d", $time,
                 m_axis_tuser, got_x, got_y, got_pix, got_err);
      end else begin
        want = expected_results.pop_front();
        if (want.kind !== m_axis_tuser || want.pos_x !== got_x || want.pos_y !== got_y ||
            want.pixel !== got_pix || want.error_code !== got_err) begin
          fail_count++;
          $display("%0t: mismatch expected kind=%0d x=%0d y=%0d pixel=%h err=%0d", $time,
                   want.kind, want.pos_x, want.pos_y, want.pixel, want.error_code);
          $display("%0t:          actual   kind=%0d x=%0d y=%0d pixel=%h err=%0d", $time,
                   m_axis_tuser, got_x, got_y, got_pix, got_err);
        end
      end
    end
  end

  // Send one byte item, with an optional gap before it
  task automatic send_byte(logic [7:0] b, logic last);
    @(negedge clk);
    if (send_gaps && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    s_axis_tlast = last;
    // Ready only moves at the rising edge, so check it mid-cycle
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
    predict_byte(b, last);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++)
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    s_axis_tlast = 1'b0;
  endtask

  // Hold until every expected result has come, then let the block settle
  task automatic wait_idle();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [11:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_SCREEN_W) scr_w = {20'd0, value};
    else scr_h = {20'd0, value};
  endtask

  function automatic logic [31:0] padded_line(logic [31:0] w, logic [15:0] d);
    logic [31:0] ln;
    ln = (w * {16'd0, d}) >> 3;
    return (ln + 3) & ~32'd3;
  endfunction

  // Build a file: header with random filler, gap to the offset or byte 64, then payload bytes
  function automatic void build_file(logic [15:0] s, logic [31:0] off, logic [31:0] w,
                                     logic [31:0] h, logic [15:0] d, logic [31:0] comp,
                                     logic [31:0] size, int payload);
    logic [7:0] hdr[54];
    foreach (hdr[i]) hdr[i] = $urandom_range(0, 255);
    for (int i = 0; i < 4; i++) begin
      if (i < 2) begin
        hdr[i] = s[8*i +: 8];
        hdr[28+i] = d[8*i +: 8];
      end
      hdr[10+i] = off[8*i +: 8];
      hdr[18+i] = w[8*i +: 8];
      hdr[22+i] = h[8*i +: 8];
      hdr[30+i] = comp[8*i +: 8];
      hdr[34+i] = size[8*i +: 8];
    end
    file_bytes.delete();
    foreach (hdr[i]) file_bytes.push_back(hdr[i]);
    for (int i = 54; i < int'(off) && i < 64; i++) file_bytes.push_back($urandom_range(0, 255));
    for (int i = 0; i < payload; i++) file_bytes.push_back($urandom_range(0, 255));
  endfunction

  // Well-formed file with exact payload plus optional trailing bytes
  task automatic send_image(logic [31:0] w, logic [31:0] h, logic [15:0] d,
                            logic [31:0] off, int trailing);
    logic [31:0] ln;
    ln = padded_line(w, d);
    build_file(BMP_SIGNATURE, off, w, h, d, 0, ln * h, int'(ln * h) + trailing);
    send_file();
  endtask

  task automatic test_pixel_formats();
    // 16-bit rows behind a skip gap, with row padding
    send_image(1, 2, 16, 56, 0);
    // extreme byte values through the 8-bit and 24-bit paths
    build_file(BMP_SIGNATURE, 54, 4, 1, 8, 0, 4, 0);
    file_bytes.push_back(8'h00); file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'hAA); file_bytes.push_back(8'h55);
    send_file();
    build_file(BMP_SIGNATURE, 54, 2, 1, 24, 0, 8, 0);
    repeat (3) file_bytes.push_back(8'hFF);
    repeat (3) file_bytes.push_back(8'h00);
    file_bytes.push_back(8'h80); file_bytes.push_back(8'h01);
    send_file();
  endtask

  task automatic test_header_checks();
    // unsupported depth, file ending on the last header byte
    build_file(BMP_SIGNATURE, 54, 1, 1, 32, 0, 4, 0); send_file();
    // truncated in the header and in the rows
    build_file(BMP_SIGNATURE, 54, 2, 2, 8, 0, 8, 0);
    file_bytes = file_bytes[0:9];
    send_file();
    build_file(BMP_SIGNATURE, 54, 1, 2, 8, 0, 8, 8);
    file_bytes = file_bytes[0:56];
    send_file();
  endtask

  task automatic test_screen_config();
    wait_idle();
    write_reg(CFG_SCREEN_W, 12'd1);
    write_reg(CFG_SCREEN_H, 12'd1);
    // too wide for the small screen
    build_file(BMP_SIGNATURE, 54, 2, 1, 8, 0, 4, 0); send_file();
    wait_idle();
    write_reg(CFG_SCREEN_W, 12'd800);
    write_reg(CFG_SCREEN_H, 12'd480);
  endtask

  task automatic test_quiet_tail();
    wait_idle();
    send_gaps = 0;
    recv_stalls = 0;
    send_image(2, 2, 24, 55, 0);
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'd0;
    s_axis_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_SCREEN_W;
    cfg_data = '0;
    scr_w = SCREEN_W_RST;
    scr_h = SCREEN_H_RST;
    clear_parse();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_pixel_formats();
    test_header_checks();
    test_screen_config();
    test_quiet_tail();

    wait_idle();
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
